FILE: src/power_budget_overcurrent_monitor_core_defines.svh
// Assertion macros for the power budget monitor checker.
// Requires clk and rst_n in the scope of use.
`ifndef POWER_BUDGET_OVERCURRENT_MONITOR_CORE_DEFINES_SVH
`define POWER_BUDGET_OVERCURRENT_MONITOR_CORE_DEFINES_SVH

// same-cycle implication
`define PBOM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbom: same-cycle check failed");

// next-cycle implication
`define PBOM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbom: next-cycle check failed");

`endif

FILE: src/pbom_pkg.sv
// Shared constants, codes and helpers for the power budget monitor.
// No dependencies.
package pbom_pkg;

    localparam int unsigned BUFFER_MAX            = 600;
    localparam int unsigned CURRENT_LIMIT_DEFAULT = 10000;
    localparam int unsigned CURRENT_LIMIT_MAX     = 20000;

    localparam int unsigned DIV_W     = 32;
    localparam int unsigned DVS_W     = 16;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

    localparam int unsigned FLAG_SWITCH = 0;
    localparam int unsigned FLAG_FIRE   = 1;
    localparam int unsigned FLAG_CUT    = 2;
    localparam int unsigned FLAG_OVL    = 3;
    localparam int unsigned FLAG_ADC    = 4;
    localparam int unsigned FLAG_EXC    = 5;
    localparam int unsigned FLAG_SAT    = 6;

    localparam logic [2:0] REQ_TICK      = 3'd0;
    localparam logic [2:0] REQ_SAMPLE    = 3'd1;
    localparam logic [2:0] REQ_SW_ON     = 3'd2;
    localparam logic [2:0] REQ_SW_OFF    = 3'd3;
    localparam logic [2:0] REQ_SET_BUF   = 3'd4;
    localparam logic [2:0] REQ_SET_LIMIT = 3'd5;

    localparam logic [1:0] FAULT_NONE = 2'd0;
    localparam logic [1:0] FAULT_ADC  = 2'd1;
    localparam logic [1:0] FAULT_OC   = 2'd2;
    localparam logic [1:0] FAULT_CUT  = 2'd3;

    localparam logic [2:0] CFG_POWER_LIMIT = 3'd0;
    localparam logic [2:0] CFG_LIMIT_EN    = 3'd1;
    localparam logic [2:0] CFG_SAMPLE_PER  = 3'd2;
    localparam logic [2:0] CFG_SETTLE_PER  = 3'd3;
    localparam logic [2:0] CFG_OC_HOLD     = 3'd4;
    localparam logic [2:0] CFG_CUT_HOLD    = 3'd5;
    localparam logic [2:0] CFG_MAX_FAIL    = 3'd6;
    localparam logic [2:0] CFG_WARNING     = 3'd7;

    typedef logic [6:0] flags_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic can_switch_on(input logic sampling, input flags_t f);
        return sampling && !f[FLAG_CUT] && !f[FLAG_OVL] && !f[FLAG_ADC];
    endfunction

    function automatic flags_t switch_off(input flags_t f);
        flags_t r;
        r = f;
        r[FLAG_SWITCH] = 1'b0;
        r[FLAG_FIRE]   = 1'b1;
        return r;
    endfunction

endpackage

FILE: src/pbom_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on pbom_pkg.
module pbom_div (
    input  logic               clk,
    input  logic               rst_n,
    input  pbom_pkg::div_req_t req,
    output pbom_pkg::div_rsp_t rsp
);
    import pbom_pkg::*;

    logic [DIV_W-1:0]          work_reg;
    logic [DVS_W:0]            rem_reg;
    logic [DVS_W-1:0]          dvs_reg;
    logic [DIV_CNT_W-1:0]      cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [DVS_W:0]            rem_sh;
    logic                      fits;

    assign rem_sh = {rem_reg[DVS_W-1:0], work_reg[DIV_W-1]};
    assign fits   = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            work_reg <= req.dividend;
            rem_reg  <= '0;
            dvs_reg  <= req.divisor;
        end
        else if (busy_reg)
        begin
            work_reg <= {work_reg[DIV_W-2:0], fits};
            rem_reg  <= fits ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = work_reg;

endmodule

FILE: src/power_budget_overcurrent_monitor_core.sv
// Ticks, samples, switch requests and settings give their status word in the next cycle;
// a window-closing sample gives it after two 32-step divisions on the shared divider.
// Throughput: one word per cycle unless in_stall, set by the divisions or an output stall.
// Reset (rst_n, async low): switch on, buffer full, default limits and settings.
// Depends on pbom_pkg and pbom_div.
module power_budget_overcurrent_monitor_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  req_type,
    input  logic [15:0] current_ma,
    input  logic [9:0]  power_w,
    input  logic        adc_start_ok,
    input  logic [15:0] setting_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        accepted,
    output logic [6:0]  status_flags,
    output logic [1:0]  fault_cause,
    output logic        adc_start,
    output logic        report_valid,
    output logic [9:0]  avg_power_w,
    output logic [9:0]  peak_power_w,
    output logic [15:0] avg_current_ma,
    output logic [15:0] buffer_deci_j
);
    import pbom_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_P_GO, S_P_WAIT, S_C_GO, S_C_WAIT} state_t;

    state_t state_reg, state_next;

    logic [9:0]  plim_reg;
    logic        len_reg;
    logic [7:0]  sper_reg;
    logic [15:0] stper_reg, ochold_reg, cuthold_reg;
    logic [7:0]  maxfail_reg;
    logic [9:0]  warn_reg;

    logic [7:0]  sel_reg, sel_next;
    logic [15:0] stel_reg, stel_next;
    logic        due_reg, due_next;
    logic [25:0] sump_reg, sump_next;
    logic [31:0] sumc_reg, sumc_next;
    logic [9:0]  peak_reg, peak_next;
    logic        risk_reg, risk_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [15:0] cut_reg, cut_next;
    logic [16:0] oce_reg, oce_next;
    logic [7:0]  fail_reg, fail_next;
    logic        son_reg, son_next;
    flags_t      flags_reg, flags_next;
    logic [1:0]  fault_reg, fault_next;
    logic [15:0] lcur_reg, lcur_next;
    logic [9:0]  lpow_reg, lpow_next;
    logic [15:0] buf_reg, buf_next;
    logic [15:0] clim_reg, clim_next;
    logic [9:0]  rp0_reg, rp0_next, rp1_reg, rp1_next;
    logic [15:0] rp2_reg, rp2_next;
    logic        ov_reg, ov_next, acc_reg, acc_next, adc_reg, adc_next, rep_reg, rep_next;

    logic        in_acc;
    div_req_t    dreq;
    div_rsp_t    drsp;

    logic [17:0] oce_sum;
    logic [9:0]  diff;
    logic [16:0] buf_up;

    assign in_stall = (state_reg != S_IDLE) || (ov_reg && out_stall);
    assign in_acc   = in_valid && !in_stall;

    assign dreq.start    = (state_reg == S_P_GO) || (state_reg == S_C_GO);
    assign dreq.dividend = (state_reg == S_P_GO) ? {6'd0, sump_reg} : sumc_reg;
    assign dreq.divisor  = cnt_reg;

    pbom_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    always_comb
    begin
        state_next = state_reg;
        sel_next = sel_reg;   stel_next = stel_reg;  due_next = due_reg;
        sump_next = sump_reg; sumc_next = sumc_reg;  peak_next = peak_reg;
        risk_next = risk_reg; cnt_next = cnt_reg;    cut_next = cut_reg;
        oce_next = oce_reg;   fail_next = fail_reg;  son_next = son_reg;
        flags_next = flags_reg; fault_next = fault_reg;
        lcur_next = lcur_reg; lpow_next = lpow_reg;  buf_next = buf_reg;
        clim_next = clim_reg; rp0_next = rp0_reg;    rp1_next = rp1_reg;
        rp2_next = rp2_reg;
        ov_next = ov_reg && out_stall;
        acc_next = acc_reg; adc_next = adc_reg; rep_next = rep_reg;
        oce_sum = 18'(oce_reg) + 18'(sper_reg);
        diff = '0;
        buf_up = '0;

        if (in_acc)
        begin
            acc_next = 1'b0;
            adc_next = 1'b0;
            rep_next = 1'b0;
            ov_next  = 1'b1;
            case (req_type)
                REQ_TICK:
                begin
                    acc_next = 1'b1;
                    if (cut_reg != 16'd0)
                    begin
                        cut_next = cut_reg - 16'd1;
                        if (cut_reg == 16'd1)
                        begin
                            flags_next[FLAG_CUT] = 1'b0;
                            if (can_switch_on(son_reg, flags_next))
                            begin
                                flags_next[FLAG_SWITCH] = 1'b1;
                                flags_next[FLAG_FIRE]   = 1'b0;
                            end
                        end
                    end
                    if (son_reg)
                    begin
                        if (sel_reg != 8'hFF)
                            sel_next = sel_reg + 8'd1;
                        if (stel_reg != 16'hFFFF)
                            stel_next = stel_reg + 16'd1;
                        if (stel_next >= stper_reg)
                        begin
                            stel_next = '0;
                            due_next  = 1'b1;
                        end
                        if (sel_next >= sper_reg)
                        begin
                            adc_next = 1'b1;
                            sel_next = '0;
                            if (adc_start_ok)
                                fail_next = '0;
                            else
                            begin
                                if (fail_reg != 8'hFF)
                                    fail_next = fail_reg + 8'd1;
                                if (fail_next >= maxfail_reg)
                                begin
                                    flags_next = switch_off(flags_next);
                                    flags_next[FLAG_ADC] = 1'b1;
                                    fault_next = FAULT_ADC;
                                    son_next   = 1'b0;
                                end
                            end
                        end
                    end
                end
                REQ_SAMPLE:
                begin
                    acc_next  = 1'b1;
                    lcur_next = current_ma;
                    lpow_next = power_w;
                    flags_next[FLAG_SAT] = power_w > warn_reg;
                    if (clim_reg != 16'd0 && current_ma >= clim_reg && !flags_reg[FLAG_OVL])
                    begin
                        oce_next = oce_sum[17] ? 17'h1FFFF : oce_sum[16:0];
                        if (oce_next >= 17'(ochold_reg))
                        begin
                            fault_next = FAULT_OC;
                            flags_next = switch_off(flags_next);
                            flags_next[FLAG_OVL] = 1'b1;
                        end
                    end
                    else if (!flags_reg[FLAG_OVL])
                        oce_next = '0;
                    if (cnt_reg != 16'hFFFF)
                    begin
                        sump_next = sump_reg + 26'(power_w);
                        sumc_next = sumc_reg + 32'(current_ma);
                        cnt_next  = cnt_reg + 16'd1;
                    end
                    if (power_w > peak_reg)
                        peak_next = power_w;
                    if (flags_next[FLAG_SAT])
                        risk_next = 1'b1;
                    if (due_reg)
                    begin
                        due_next   = 1'b0;
                        ov_next    = 1'b0;
                        state_next = S_P_GO;
                    end
                end
                REQ_SW_ON:
                begin
                    if (can_switch_on(son_reg, flags_reg))
                    begin
                        flags_next[FLAG_SWITCH] = 1'b1;
                        flags_next[FLAG_FIRE]   = 1'b0;
                        acc_next = 1'b1;
                    end
                end
                REQ_SW_OFF:
                begin
                    flags_next = switch_off(flags_reg);
                    acc_next   = 1'b1;
                end
                REQ_SET_BUF:
                begin
                    if (setting_value <= 16'(BUFFER_MAX))
                    begin
                        buf_next = setting_value;
                        acc_next = 1'b1;
                    end
                end
                REQ_SET_LIMIT:
                begin
                    if (setting_value <= 16'(CURRENT_LIMIT_MAX))
                    begin
                        clim_next = setting_value;
                        oce_next  = '0;
                        if (setting_value == 16'd0 || lcur_reg < setting_value)
                            flags_next[FLAG_OVL] = 1'b0;
                        acc_next = 1'b1;
                    end
                end
                default:
                begin
                    acc_next = 1'b0;
                end
            endcase
        end
        else
        begin
            case (state_reg)
                S_P_GO:
                    state_next = S_P_WAIT;
                S_P_WAIT:
                begin
                    if (drsp.done)
                    begin
                        rp0_next   = drsp.quotient[9:0];
                        state_next = S_C_GO;
                    end
                end
                S_C_GO:
                    state_next = S_C_WAIT;
                S_C_WAIT:
                begin
                    if (drsp.done)
                    begin
                        rp2_next  = drsp.quotient[15:0];
                        rp1_next  = peak_reg;
                        flags_next[FLAG_SAT] = risk_reg;
                        flags_next[FLAG_EXC] = 1'b0;
                        sump_next = '0;
                        sumc_next = '0;
                        peak_next = '0;
                        risk_next = 1'b0;
                        cnt_next  = '0;
                        if (len_reg)
                        begin
                            if (lpow_reg > plim_reg)
                            begin
                                diff = lpow_reg - plim_reg;
                                flags_next[FLAG_EXC] = 1'b1;
                                buf_next = (16'(diff) >= buf_reg) ? 16'd0 :
                                           buf_reg - 16'(diff);
                            end
                            else
                            begin
                                diff   = plim_reg - lpow_reg;
                                buf_up = 17'(diff) + 17'(buf_reg);
                                buf_next = (buf_up >= 17'(BUFFER_MAX)) ? 16'(BUFFER_MAX) :
                                           buf_up[15:0];
                            end
                            if (buf_next == 16'd0 && flags_next[FLAG_EXC] &&
                                !flags_next[FLAG_CUT])
                            begin
                                flags_next = switch_off(flags_next);
                                flags_next[FLAG_CUT] = 1'b1;
                                fault_next = FAULT_CUT;
                                cut_next   = (cuthold_reg == 16'd0) ? 16'd1 : cuthold_reg;
                            end
                        end
                        acc_next   = 1'b1;
                        adc_next   = 1'b0;
                        rep_next   = 1'b1;
                        ov_next    = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                default:
                    state_next = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            plim_reg <= 10'd60;   len_reg <= 1'b1;      sper_reg <= 8'd1;
            stper_reg <= 16'd100; ochold_reg <= 16'd10; cuthold_reg <= 16'd1000;
            maxfail_reg <= 8'd3;  warn_reg <= 10'd500;
            sel_reg <= '0;  stel_reg <= '0; due_reg <= 1'b0;
            sump_reg <= '0; sumc_reg <= '0; peak_reg <= '0; risk_reg <= 1'b0;
            cnt_reg <= '0;  cut_reg <= '0;  oce_reg <= '0;  fail_reg <= '0;
            son_reg <= 1'b1;
            flags_reg <= flags_t'(1) << FLAG_SWITCH;
            fault_reg <= FAULT_NONE;
            lcur_reg <= '0; lpow_reg <= '0;
            buf_reg  <= 16'(BUFFER_MAX);
            clim_reg <= 16'(CURRENT_LIMIT_DEFAULT);
            rp0_reg <= '0; rp1_reg <= '0; rp2_reg <= '0;
            ov_reg <= 1'b0; acc_reg <= 1'b0; adc_reg <= 1'b0; rep_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg <= sel_next;   stel_reg <= stel_next; due_reg <= due_next;
            sump_reg <= sump_next; sumc_reg <= sumc_next; peak_reg <= peak_next;
            risk_reg <= risk_next; cnt_reg <= cnt_next;   cut_reg <= cut_next;
            oce_reg <= oce_next;   fail_reg <= fail_next; son_reg <= son_next;
            flags_reg <= flags_next; fault_reg <= fault_next;
            lcur_reg <= lcur_next; lpow_reg <= lpow_next; buf_reg <= buf_next;
            clim_reg <= clim_next; rp0_reg <= rp0_next;   rp1_reg <= rp1_next;
            rp2_reg <= rp2_next;
            ov_reg <= ov_next; acc_reg <= acc_next; adc_reg <= adc_next; rep_reg <= rep_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_POWER_LIMIT: plim_reg    <= cfg_data[9:0];
                    CFG_LIMIT_EN:    len_reg     <= cfg_data[0];
                    CFG_SAMPLE_PER:  sper_reg    <= cfg_data[7:0];
                    CFG_SETTLE_PER:  stper_reg   <= cfg_data;
                    CFG_OC_HOLD:     ochold_reg  <= cfg_data;
                    CFG_CUT_HOLD:    cuthold_reg <= cfg_data;
                    CFG_MAX_FAIL:    maxfail_reg <= cfg_data[7:0];
                    CFG_WARNING:     warn_reg    <= cfg_data[9:0];
                    default:         warn_reg    <= warn_reg;
                endcase
            end
        end
    end

    assign out_valid      = ov_reg;
    assign accepted       = acc_reg;
    assign status_flags   = flags_reg;
    assign fault_cause    = fault_reg;
    assign adc_start      = adc_reg;
    assign report_valid   = rep_reg;
    assign avg_power_w    = rp0_reg;
    assign peak_power_w   = rp1_reg;
    assign avg_current_ma = rp2_reg;
    assign buffer_deci_j  = buf_reg;

endmodule

FILE: src/pbom_checker.sv
// Port-level checks for the power budget monitor, bound to the top level.
// Depends on pbom_pkg and power_budget_overcurrent_monitor_core_defines.svh.
`include "power_budget_overcurrent_monitor_core_defines.svh"

module pbom_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       accepted,
    input logic       adc_start,
    input logic       report_valid,
    input logic [6:0] status_flags
);
    import pbom_pkg::*;

    `PBOM_ASSERT_IMP(a_no_accept_when_full, in_valid && !in_stall, !(out_valid && out_stall))
    `PBOM_ASSERT_IMP(a_report_accepted, out_valid && report_valid, accepted && !adc_start)
    `PBOM_ASSERT_IMP(a_cut_switch_off, out_valid && (status_flags[FLAG_CUT] || status_flags[FLAG_ADC]), !status_flags[FLAG_SWITCH])
    `PBOM_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(report_valid))
endmodule

bind power_budget_overcurrent_monitor_core pbom_checker u_pbom_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .accepted     (accepted),
    .adc_start    (adc_start),
    .report_valid (report_valid),
    .status_flags (status_flags)
);

FILE: test/power_budget_overcurrent_monitor_core_tb.sv
// Testbench for power_budget_overcurrent_monitor_core: directed and random requests
// checked word by word against a behavioral predictor of the monitor state.
// Depends on pbom_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module power_budget_overcurrent_monitor_core_tb;
    import pbom_pkg::*;

    localparam logic [2:0] REQ_RSVD6 = 3'd6;
    localparam logic [2:0] REQ_RSVD7 = 3'd7;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic        acc;
        logic [6:0]  flags;
        logic [1:0]  fault;
        logic        start;
        logic        report;
        logic [9:0]  avg_p;
        logic [9:0]  peak_p;
        logic [15:0] avg_c;
        logic [15:0] buf_dj;
    } status_word_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  req_type;
    logic [15:0] current_ma;
    logic [9:0]  power_w;
    logic        adc_start_ok;
    logic [15:0] setting_value;
    logic        out_valid;
    logic        out_stall;
    logic        accepted;
    logic [6:0]  status_flags;
    logic [1:0]  fault_cause;
    logic        adc_start;
    logic        report_valid;
    logic [9:0]  avg_power_w;
    logic [9:0]  peak_power_w;
    logic [15:0] avg_current_ma;
    logic [15:0] buffer_deci_j;

    power_budget_overcurrent_monitor_core uut (.*);

    // settings shadow
    bit [9:0]  lim_w;
    bit        lim_en;
    bit [7:0]  smp_per;
    bit [15:0] stl_per;
    bit [15:0] oc_hold;
    bit [15:0] cut_hold;
    bit [7:0]  max_fail;
    bit [9:0]  warn_w;

    // monitor state
    bit [7:0]  smp_el;
    bit [15:0] stl_el;
    bit        stl_due;
    bit [25:0] sum_p;
    bit [31:0] sum_c;
    bit [9:0]  win_peak;
    bit        win_risk;
    bit [15:0] win_cnt;
    bit [15:0] cut_left;
    bit [16:0] oc_el;
    bit [7:0]  fails;
    bit        smp_on;
    bit [6:0]  flags;
    bit [1:0]  fault;
    bit [15:0] last_c;
    bit [9:0]  last_p;
    bit [15:0] energy;
    bit [15:0] cur_lim;
    bit [9:0]  rep_avg_p;
    bit [9:0]  rep_peak;
    bit [15:0] rep_avg_c;

    status_word_t expected_words[$];
    int errors;
    int tx_pct;
    int rx_pct;
    int hold_left;
    int idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit switch_allowed();
        return smp_on && !flags[FLAG_CUT] && !flags[FLAG_OVL] && !flags[FLAG_ADC];
    endfunction

    function automatic void force_off();
        flags[FLAG_SWITCH] = 1'b0;
        flags[FLAG_FIRE] = 1'b1;
    endfunction

    function automatic void settle_energy();
        int unsigned diff;
        flags[FLAG_EXC] = 1'b0;
        if (!lim_en)
            return;
        if (last_p > lim_w)
        begin
            diff = last_p - lim_w;
            flags[FLAG_EXC] = 1'b1;
            energy = (diff >= energy) ? 16'd0 : 16'(energy - diff);
        end
        else
        begin
            diff = lim_w - last_p;
            energy = (diff + energy >= BUFFER_MAX) ? 16'(BUFFER_MAX) : 16'(energy + diff);
        end
        if (energy == 0 && flags[FLAG_EXC] && !flags[FLAG_CUT])
        begin
            force_off();
            flags[FLAG_CUT] = 1'b1;
            fault = FAULT_CUT;
            cut_left = (cut_hold == 0) ? 16'd1 : cut_hold;
        end
    endfunction

    function automatic status_word_t predict_status(logic [2:0] req, logic [15:0] cur,
                                                    logic [9:0] pwr, logic ok,
                                                    logic [15:0] val);
        status_word_t w;
        int unsigned t;
        w = '0;
        case (req)
            REQ_TICK:
            begin
                w.acc = 1'b1;
                if (cut_left > 0)
                begin
                    cut_left--;
                    if (cut_left == 0)
                    begin
                        flags[FLAG_CUT] = 1'b0;
                        if (switch_allowed())
                        begin
                            flags[FLAG_SWITCH] = 1'b1;
                            flags[FLAG_FIRE] = 1'b0;
                        end
                    end
                end
                if (smp_on)
                begin
                    if (smp_el != 8'hFF) smp_el++;
                    if (stl_el != 16'hFFFF) stl_el++;
                    if (stl_el >= stl_per)
                    begin
                        stl_el = 0;
                        stl_due = 1'b1;
                    end
                    if (smp_el >= smp_per)
                    begin
                        w.start = 1'b1;
                        if (ok)
                            fails = 0;
                        else
                        begin
                            if (fails != 8'hFF) fails++;
                            if (fails >= max_fail)
                            begin
                                flags[FLAG_ADC] = 1'b1;
                                fault = FAULT_ADC;
                                smp_on = 1'b0;
                                force_off();
                            end
                        end
                        smp_el = 0;
                    end
                end
            end
            REQ_SAMPLE:
            begin
                w.acc = 1'b1;
                last_c = cur;
                last_p = pwr;
                flags[FLAG_SAT] = (pwr > warn_w);
                if (cur_lim != 0 && cur >= cur_lim && !flags[FLAG_OVL])
                begin
                    t = oc_el + smp_per;
                    oc_el = (t > 17'h1FFFF) ? 17'h1FFFF : 17'(t);
                    if (oc_el >= oc_hold)
                    begin
                        fault = FAULT_OC;
                        flags[FLAG_OVL] = 1'b1;
                        force_off();
                    end
                end
                else if (!flags[FLAG_OVL])
                    oc_el = 0;
                if (win_cnt != 16'hFFFF)
                begin
                    sum_p += pwr;
                    sum_c += cur;
                    win_cnt++;
                end
                if (pwr > win_peak) win_peak = pwr;
                if (flags[FLAG_SAT]) win_risk = 1'b1;
                if (stl_due)
                begin
                    stl_due = 1'b0;
                    rep_avg_p = 10'(sum_p / win_cnt);
                    rep_peak = win_peak;
                    rep_avg_c = 16'(sum_c / win_cnt);
                    flags[FLAG_SAT] = win_risk;
                    sum_p = 0;
                    sum_c = 0;
                    win_peak = 0;
                    win_risk = 0;
                    win_cnt = 0;
                    settle_energy();
                    w.report = 1'b1;
                end
            end
            REQ_SW_ON:
                if (switch_allowed())
                begin
                    flags[FLAG_SWITCH] = 1'b1;
                    flags[FLAG_FIRE] = 1'b0;
                    w.acc = 1'b1;
                end
            REQ_SW_OFF:
            begin
                force_off();
                w.acc = 1'b1;
            end
            REQ_SET_BUF:
                if (val <= BUFFER_MAX)
                begin
                    energy = val;
                    w.acc = 1'b1;
                end
            REQ_SET_LIMIT:
                if (val <= CURRENT_LIMIT_MAX)
                begin
                    cur_lim = val;
                    oc_el = 0;
                    if (val == 0 || last_c < val)
                        flags[FLAG_OVL] = 1'b0;
                    w.acc = 1'b1;
                end
            default: ;
        endcase
        w.flags = flags;
        w.fault = fault;
        w.avg_p = rep_avg_p;
        w.peak_p = rep_peak;
        w.avg_c = rep_avg_c;
        w.buf_dj = energy;
        return w;
    endfunction

    task automatic send_word(logic [2:0] req, logic [15:0] cur, logic [9:0] pwr,
                             logic ok, logic [15:0] val);
        while ($urandom_range(99) < tx_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        current_ma <= cur;
        power_w <= pwr;
        adc_start_ok <= ok;
        setting_value <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_words.push_back(predict_status(req, cur, pwr, ok, val));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            CFG_POWER_LIMIT: lim_w = val[9:0];
            CFG_LIMIT_EN:    lim_en = val[0];
            CFG_SAMPLE_PER:  smp_per = val[7:0];
            CFG_SETTLE_PER:  stl_per = val;
            CFG_OC_HOLD:     oc_hold = val;
            CFG_CUT_HOLD:    cut_hold = val;
            CFG_MAX_FAIL:    max_fail = val[7:0];
            default:         warn_w = val[9:0];
        endcase
    endtask

    task automatic configure(int plim, int len, int sper, int stper, int och, int cuth,
                             int mf, int warn);
        drain();
        write_reg(CFG_POWER_LIMIT, 16'(plim));
        write_reg(CFG_LIMIT_EN, 16'(len));
        write_reg(CFG_SAMPLE_PER, 16'(sper));
        write_reg(CFG_SETTLE_PER, 16'(stper));
        write_reg(CFG_OC_HOLD, 16'(och));
        write_reg(CFG_CUT_HOLD, 16'(cuth));
        write_reg(CFG_MAX_FAIL, 16'(mf));
        write_reg(CFG_WARNING, 16'(warn));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_random();
        int r;
        logic [2:0] req;
        logic [15:0] cur;
        logic [15:0] val;
        r = $urandom_range(99);
        if (r < 40) req = REQ_TICK;
        else if (r < 72) req = REQ_SAMPLE;
        else if (r < 78) req = REQ_SW_ON;
        else if (r < 82) req = REQ_SW_OFF;
        else if (r < 88) req = REQ_SET_BUF;
        else if (r < 95) req = REQ_SET_LIMIT;
        else req = $urandom_range(1) ? REQ_RSVD6 : REQ_RSVD7;
        cur = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(20000));
        val = $urandom_range(2) == 0 ? 16'($urandom) :
              (req == REQ_SET_BUF ? 16'($urandom_range(BUFFER_MAX))
                                  : 16'($urandom_range(CURRENT_LIMIT_MAX)));
        send_word(req, cur, 10'($urandom), $urandom_range(19) != 0, val);
    endtask

    task automatic run_random(int n);
        repeat (n) send_random();
    endtask

    task automatic test_directed();
        configure(60, 1, 1, 2, 2, 1, 255, 500);
        send_word(REQ_SAMPLE, 16'd0, 10'd0, 1'b1, 16'd0);
        send_word(REQ_SW_OFF, 16'd0, 10'd0, 1'b1, 16'd0);
        send_word(REQ_SW_ON, 16'd0, 10'd0, 1'b1, 16'd0);
        send_word(REQ_RSVD6, 16'hFFFF, 10'h3FF, 1'b1, 16'hFFFF);
        send_word(REQ_RSVD7, 16'd0, 10'd0, 1'b0, 16'd0);
        send_word(REQ_SAMPLE, 16'hFFFF, 10'h3FF, 1'b1, 16'd0);
        send_word(REQ_SAMPLE, 16'hFFFF, 10'h3FF, 1'b1, 16'd0);
        send_word(REQ_SW_ON, 16'd0, 10'd0, 1'b1, 16'd0);
        send_word(REQ_SET_LIMIT, 16'd0, 10'd0, 1'b1, 16'd20001);
        send_word(REQ_SET_LIMIT, 16'd0, 10'd0, 1'b1, 16'd20000);
        send_word(REQ_SET_LIMIT, 16'd0, 10'd0, 1'b1, 16'd0);
        send_word(REQ_SW_ON, 16'd0, 10'd0, 1'b1, 16'd0);
        send_word(REQ_SET_BUF, 16'd0, 10'd0, 1'b1, 16'd601);
        send_word(REQ_SET_BUF, 16'd0, 10'd0, 1'b1, 16'hFFFF);
        send_word(REQ_SET_BUF, 16'd0, 10'd0, 1'b1, 16'd0);
        send_word(REQ_TICK, 16'd0, 10'd0, 1'b0, 16'd0);
        send_word(REQ_TICK, 16'd0, 10'd0, 1'b1, 16'd0);
        send_word(REQ_SAMPLE, 16'd100, 10'h3FF, 1'b1, 16'd0);
        send_word(REQ_SW_ON, 16'd0, 10'd0, 1'b1, 16'd0);
        send_word(REQ_TICK, 16'd0, 10'd0, 1'b1, 16'd0);
        send_word(REQ_SW_ON, 16'd0, 10'd0, 1'b1, 16'd0);
        send_word(REQ_SET_LIMIT, 16'd0, 10'd0, 1'b1, 16'd10000);
        send_word(REQ_SET_BUF, 16'd0, 10'd0, 1'b1, 16'd600);
    endtask

    task automatic test_random_phases();
        tx_pct = 30;
        rx_pct = 81;
        configure(1, 1, 1, 5, 3, 4, 255, 0);
        run_random(350);
        tx_pct = 81;
        rx_pct = 30;
        configure(1023, 0, 255, 1, 65535, 65535, 200, 1023);
        run_random(300);
        tx_pct = 0;
        rx_pct = 0;
        configure(300, 1, 2, 3, 1, 1, 100, 700);
        run_random(300);
    endtask

    task automatic test_backpressure();
        drain();
        hold_left = 400;
        run_random(60);
    endtask

    task automatic test_full_window();
        configure(500, 1, 255, 20, 65535, 2, 255, 600);
        repeat (20) send_word(REQ_SAMPLE, 16'hFFFF, 10'h3FF, 1'b1, 16'd0);
        repeat (20) send_word(REQ_TICK, 16'd0, 10'd0, 1'b1, 16'd0);
        send_word(REQ_SAMPLE, 16'hFFFF, 10'h3FF, 1'b1, 16'd0);
    endtask

    task automatic test_adc_fault();
        tx_pct = 30;
        rx_pct = 30;
        configure(60, 1, 1, 4, 10, 3, 1, 500);
        send_word(REQ_TICK, 16'd0, 10'd0, 1'b0, 16'd0);
        send_word(REQ_SW_ON, 16'd0, 10'd0, 1'b1, 16'd0);
        run_random(60);
    endtask

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < rx_pct);
    end

    always @(posedge clk)
    begin
        status_word_t got;
        status_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {accepted, status_flags, fault_cause, adc_start, report_valid,
                   avg_power_w, peak_power_w, avg_current_ma, buffer_deci_j};
            if (expected_words.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: %p", got);
            end
            else
            begin
                want = expected_words.pop_front();
                if (got != want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        req_type = '0;
        current_ma = '0;
        power_w = '0;
        adc_start_ok = 1'b0;
        setting_value = '0;
        out_stall = 1'b0;
        errors = 0;
        tx_pct = 0;
        rx_pct = 0;
        hold_left = 0;
        idle_cycles = 0;
        lim_w = 60; lim_en = 1; smp_per = 1; stl_per = 100;
        oc_hold = 10; cut_hold = 1000; max_fail = 3; warn_w = 500;
        smp_el = 0; stl_el = 0; stl_due = 0; sum_p = 0; sum_c = 0;
        win_peak = 0; win_risk = 0; win_cnt = 0; cut_left = 0; oc_el = 0;
        fails = 0; smp_on = 1; flags = 7'b0000001; fault = FAULT_NONE;
        last_c = 0; last_p = 0; energy = 16'(BUFFER_MAX);
        cur_lim = 16'(CURRENT_LIMIT_DEFAULT);
        rep_avg_p = 0; rep_peak = 0; rep_avg_c = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_phases();
        test_backpressure();
        test_full_window();
        test_adc_fault();
        drain();

        errors += expected_words.size();
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
